// ===== rtl/priority_collection_with_promote_unit_macros.svh =====
// Assertion helpers for the priority collection checker.
`ifndef PRIORITY_COLLECTION_WITH_PROMOTE_UNIT_MACROS_SVH
`define PRIORITY_COLLECTION_WITH_PROMOTE_UNIT_MACROS_SVH

// Checked only while out of reset.
`define PCWP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PCWP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/pcwp_pkg.sv =====
package pcwp_pkg;

    localparam int ID_W     = 8;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 3'd0,
        CMD_PROMOTE = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_POP     = 3'd3,
        CMD_QUERY   = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DEAD  = 2'd3
    } t_status;

    // memory read address source
    typedef enum logic [1:0] {
        RD_ID,
        RD_SCAN,
        RD_BEST
    } t_rd_sel;

    // result being formed
    typedef enum logic [1:0] {
        RES_ADD,
        RES_ID,
        RES_MAX,
        RES_NOP
    } t_res_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_READ_ID,
        S_ID_RES,
        S_SCAN,
        S_FETCH,
        S_MAX_RES,
        S_NOP
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     scan_clr;
        logic     scan_step;
        logic     load_res;
        t_rd_sel  rd_sel;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
        logic scan_end;
    } t_dp_stat;

endpackage

// ===== rtl/pcwp_ctrl.sv =====
module pcwp_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [pcwp_pkg::CMD_W-1:0]    i_cmd,
    input  pcwp_pkg::t_dp_stat            i_stat,
    output logic                          o_ready,
    output pcwp_pkg::t_dp_cmd             o_ctl
);

    pcwp_pkg::t_state r_state;
    pcwp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcwp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_ready           = 1'b0;
        o_ctl.capture     = 1'b0;
        o_ctl.scan_clr    = 1'b0;
        o_ctl.scan_step   = 1'b0;
        o_ctl.load_res    = 1'b0;
        o_ctl.rd_sel      = pcwp_pkg::RD_SCAN;
        o_ctl.res_sel     = pcwp_pkg::RES_NOP;
        unique case (r_state)
            pcwp_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.capture = 1'b1;
                    unique case (i_cmd)
                        pcwp_pkg::CMD_ADD: begin
                            n_state = pcwp_pkg::S_ADD;
                        end
                        pcwp_pkg::CMD_PROMOTE, pcwp_pkg::CMD_QUERY: begin
                            n_state = pcwp_pkg::S_READ_ID;
                        end
                        pcwp_pkg::CMD_PEEK, pcwp_pkg::CMD_POP: begin
                            o_ctl.scan_clr = 1'b1;
                            n_state        = pcwp_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = pcwp_pkg::S_NOP;
                        end
                    endcase
                end
            end
            pcwp_pkg::S_ADD: begin
                o_ctl.res_sel = pcwp_pkg::RES_ADD;
                if (!i_stat.out_busy) begin
                    o_ctl.load_res = 1'b1;
                    n_state        = pcwp_pkg::S_IDLE;
                end
            end
            pcwp_pkg::S_READ_ID: begin
                o_ctl.rd_sel = pcwp_pkg::RD_ID;
                n_state      = pcwp_pkg::S_ID_RES;
            end
            pcwp_pkg::S_ID_RES: begin
                o_ctl.rd_sel  = pcwp_pkg::RD_ID;
                o_ctl.res_sel = pcwp_pkg::RES_ID;
                if (!i_stat.out_busy) begin
                    o_ctl.load_res = 1'b1;
                    n_state        = pcwp_pkg::S_IDLE;
                end
            end
            pcwp_pkg::S_SCAN: begin
                o_ctl.rd_sel = pcwp_pkg::RD_SCAN;
                if (i_stat.scan_end) begin
                    n_state = pcwp_pkg::S_FETCH;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            pcwp_pkg::S_FETCH: begin
                o_ctl.rd_sel = pcwp_pkg::RD_BEST;
                n_state      = pcwp_pkg::S_MAX_RES;
            end
            pcwp_pkg::S_MAX_RES: begin
                o_ctl.rd_sel  = pcwp_pkg::RD_BEST;
                o_ctl.res_sel = pcwp_pkg::RES_MAX;
                if (!i_stat.out_busy) begin
                    o_ctl.load_res = 1'b1;
                    n_state        = pcwp_pkg::S_IDLE;
                end
            end
            pcwp_pkg::S_NOP: begin
                o_ctl.res_sel = pcwp_pkg::RES_NOP;
                if (!i_stat.out_busy) begin
                    o_ctl.load_res = 1'b1;
                    n_state        = pcwp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcwp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pcwp_datapath.sv =====
module pcwp_datapath #(
    parameter int CAPACITY       = 256,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [pcwp_pkg::CMD_W-1:0]       i_cmd,
    input  logic [pcwp_pkg::ID_W-1:0]        i_entry_id,
    input  logic [DATA_WIDTH-1:0]            i_data_value,
    input  pcwp_pkg::t_dp_cmd                i_ctl,
    output pcwp_pkg::t_dp_stat               o_stat,
    input  logic                             i_ready,
    output logic                             o_valid,
    output logic [pcwp_pkg::ID_W-1:0]        o_result_id,
    output logic [DATA_WIDTH-1:0]            o_result_value,
    output logic [PRIORITY_WIDTH-1:0]        o_result_priority,
    output logic                             o_entry_live,
    output logic [pcwp_pkg::STATUS_W-1:0]    o_status
);

    localparam int ID_W  = pcwp_pkg::ID_W;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

    // entries at or above the fill count are not written since reset: live only below it
    logic                      live_mem [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] pri_mem  [CAPACITY];
    logic [DATA_WIDTH-1:0]     val_mem  [CAPACITY];

    logic [pcwp_pkg::CMD_W-1:0] r_cmd;
    logic [ID_W-1:0]            r_id;
    logic [DATA_WIDTH-1:0]      r_data;
    logic [CNT_W-1:0]           r_next_id;
    logic [CNT_W-1:0]           r_scan_idx;
    logic                       r_cmp_vld;
    logic [IDX_W-1:0]           r_cmp_idx;
    logic                       r_found;
    logic [IDX_W-1:0]           r_best_idx;
    logic [PRIORITY_WIDTH-1:0]  r_best_pri;
    logic                       r_rd_live;
    logic [PRIORITY_WIDTH-1:0]  r_rd_pri;
    logic [DATA_WIDTH-1:0]      r_rd_value;

    logic                       r_out_valid;
    logic [ID_W-1:0]            r_res_id;
    logic [DATA_WIDTH-1:0]      r_res_value;
    logic [PRIORITY_WIDTH-1:0]  r_res_pri;
    logic                       r_res_live;
    pcwp_pkg::t_status          r_res_status;

    logic [ID_W-1:0]            n_res_id;
    logic [DATA_WIDTH-1:0]      n_res_value;
    logic [PRIORITY_WIDTH-1:0]  n_res_pri;
    logic                       n_res_live;
    pcwp_pkg::t_status          n_res_status;

    logic [CMP_W-1:0]           id_ext;
    logic [CMP_W-1:0]           cnt_ext;
    logic                       id_hit;
    logic                       full;
    logic [IDX_W-1:0]           rd_addr;
    logic [PRIORITY_WIDTH-1:0]  pri_inc;
    logic                       cmp_take;

    logic                       live_we;
    logic [IDX_W-1:0]           live_waddr;
    logic                       live_wdata;
    logic                       pri_we;
    logic [IDX_W-1:0]           pri_waddr;
    logic [PRIORITY_WIDTH-1:0]  pri_wdata;
    logic                       val_we;

    assign id_ext   = CMP_W'(r_id);
    assign cnt_ext  = CMP_W'(r_next_id);
    assign id_hit   = (id_ext < cnt_ext) && r_rd_live;
    assign full     = (r_next_id == CNT_W'(CAPACITY));
    assign pri_inc  = (&r_rd_pri) ? r_rd_pri : r_rd_pri + PRIORITY_WIDTH'(1);
    assign cmp_take = r_cmp_vld && r_rd_live && (!r_found || (r_rd_pri >= r_best_pri));

    assign o_stat.out_busy = r_out_valid && !i_ready;
    assign o_stat.scan_end = (r_scan_idx == r_next_id);

    always_comb begin
        unique case (i_ctl.rd_sel)
            pcwp_pkg::RD_ID:   rd_addr = id_ext[IDX_W-1:0];
            pcwp_pkg::RD_SCAN: rd_addr = r_scan_idx[IDX_W-1:0];
            pcwp_pkg::RD_BEST: rd_addr = r_best_idx;
            default:           rd_addr = r_best_idx;
        endcase
    end

    // result formation and store writes
    always_comb begin
        n_res_id     = '0;
        n_res_value  = '0;
        n_res_pri    = '0;
        n_res_live   = 1'b0;
        n_res_status = pcwp_pkg::ST_OK;
        live_we      = 1'b0;
        live_waddr   = r_next_id[IDX_W-1:0];
        live_wdata   = 1'b1;
        pri_we       = 1'b0;
        pri_waddr    = r_next_id[IDX_W-1:0];
        pri_wdata    = '0;
        val_we       = 1'b0;
        unique case (i_ctl.res_sel)
            pcwp_pkg::RES_ADD: begin
                if (full) begin
                    n_res_status = pcwp_pkg::ST_FULL;
                end else begin
                    n_res_id = ID_W'(r_next_id[IDX_W-1:0]);
                    live_we  = i_ctl.load_res;
                    pri_we   = i_ctl.load_res;
                    val_we   = i_ctl.load_res;
                end
            end
            pcwp_pkg::RES_ID: begin
                n_res_id = r_id;
                if (!id_hit) begin
                    n_res_status = pcwp_pkg::ST_DEAD;
                end else if (r_cmd == pcwp_pkg::CMD_PROMOTE) begin
                    n_res_pri = pri_inc;
                    pri_we    = i_ctl.load_res;
                    pri_waddr = id_ext[IDX_W-1:0];
                    pri_wdata = pri_inc;
                end else begin
                    n_res_live  = 1'b1;
                    n_res_value = r_rd_value;
                    n_res_pri   = r_rd_pri;
                end
            end
            pcwp_pkg::RES_MAX: begin
                if (!r_found) begin
                    n_res_status = pcwp_pkg::ST_EMPTY;
                end else begin
                    n_res_id    = ID_W'(r_best_idx);
                    n_res_value = r_rd_value;
                    n_res_pri   = r_best_pri;
                    if (r_cmd == pcwp_pkg::CMD_POP) begin
                        live_we    = i_ctl.load_res;
                        live_waddr = r_best_idx;
                        live_wdata = 1'b0;
                    end
                end
            end
            pcwp_pkg::RES_NOP: begin
                n_res_status = pcwp_pkg::ST_OK;
            end
            default: begin
                n_res_status = pcwp_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (live_we) begin
            live_mem[live_waddr] <= live_wdata;
        end
        r_rd_live <= live_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pri_we) begin
            pri_mem[pri_waddr] <= pri_wdata;
        end
        r_rd_pri <= pri_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            val_mem[r_next_id[IDX_W-1:0]] <= r_data;
        end
        r_rd_value <= val_mem[rd_addr];
    end

    // command capture, scan payload and result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd  <= i_cmd;
            r_id   <= i_entry_id;
            r_data <= i_data_value;
        end
        r_cmp_idx <= r_scan_idx[IDX_W-1:0];
        if (cmp_take) begin
            r_best_idx <= r_cmp_idx;
            r_best_pri <= r_rd_pri;
        end
        if (i_ctl.load_res) begin
            r_res_id     <= n_res_id;
            r_res_value  <= n_res_value;
            r_res_pri    <= n_res_pri;
            r_res_live   <= n_res_live;
            r_res_status <= n_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id   <= '0;
            r_scan_idx  <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (live_we && live_wdata) begin
                r_next_id <= r_next_id + CNT_W'(1);
            end
            if (i_ctl.scan_clr) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end else begin
                if (i_ctl.scan_step) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
                if (cmp_take) begin
                    r_found <= 1'b1;
                end
            end
            r_cmp_vld <= i_ctl.scan_step;
            if (i_ctl.load_res) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_id       = r_res_id;
    assign o_result_value    = r_res_value;
    assign o_result_priority = r_res_pri;
    assign o_entry_live      = r_res_live;
    assign o_status          = r_res_status;

endmodule

// ===== rtl/priority_collection_with_promote_unit.sv =====
// Channel   Handshake            Payload
// request   i_valid / o_ready    i_cmd, i_entry_id, i_data_value
// result    o_valid / i_ready    o_result_id, o_result_value, o_result_priority,
//                                o_entry_live, o_status
//
// After transfer, add passes S_ADD, promote and query S_READ_ID and S_ID_RES,
// peek and pop S_SCAN (one entry per cycle over the N ids handed out so far,
// via the live and priority memories), S_FETCH, S_MAX_RES; others S_NOP.
// Reset (synchronous, active low) clears the fill count and control; no clearing
// pass, an entry at or above the fill count reads as not live.
// One request is in work at a time; the result waits in an output register and
// the next request is taken meanwhile, its result holding back until it drains.
module priority_collection_with_promote_unit #(
    parameter int CAPACITY       = 256,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [pcwp_pkg::CMD_W-1:0]       i_cmd,
    input  logic [pcwp_pkg::ID_W-1:0]        i_entry_id,
    input  logic [DATA_WIDTH-1:0]            i_data_value,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pcwp_pkg::ID_W-1:0]        o_result_id,
    output logic [DATA_WIDTH-1:0]            o_result_value,
    output logic [PRIORITY_WIDTH-1:0]        o_result_priority,
    output logic                             o_entry_live,
    output logic [pcwp_pkg::STATUS_W-1:0]    o_status
);

    // controller to datapath commands, datapath to controller status
    pcwp_pkg::t_dp_cmd  ctl;
    pcwp_pkg::t_dp_stat stat;

    // sequencer: decode on transfer, then add / id lookup / max scan / no-op paths
    pcwp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_ready (o_ready),
        .o_ctl   (ctl)
    );

    // stores, fill count, scan compare and output register
    pcwp_datapath #(
        .CAPACITY       (CAPACITY),
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (i_cmd),
        .i_entry_id        (i_entry_id),
        .i_data_value      (i_data_value),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_result_id       (o_result_id),
        .o_result_value    (o_result_value),
        .o_result_priority (o_result_priority),
        .o_entry_live      (o_entry_live),
        .o_status          (o_status)
    );

endmodule

// ===== rtl/pcwp_checker.sv =====
`include "priority_collection_with_promote_unit_macros.svh"

module pcwp_checker #(
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [pcwp_pkg::ID_W-1:0]        o_result_id,
    input logic [DATA_WIDTH-1:0]            o_result_value,
    input logic [PRIORITY_WIDTH-1:0]        o_result_priority,
    input logic                             o_entry_live,
    input logic [pcwp_pkg::STATUS_W-1:0]    o_status
);

    `PCWP_ASSERT_ALWAYS(a_reset_no_result, !i_rst_n |=> !o_valid, "result valid after reset")

    `PCWP_ASSERT(a_result_hold, o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_result_id) && $stable(o_result_value), "stalled result changed")

    `PCWP_ASSERT(a_one_in_work, i_valid && o_ready |=> !o_ready, "second request taken while one in work")

    `PCWP_ASSERT(a_live_means_ok, o_valid && o_entry_live |-> o_status == pcwp_pkg::ST_OK, "live entry reported with error status")

    `PCWP_ASSERT(a_empty_zero, o_valid && o_status == pcwp_pkg::ST_EMPTY |-> o_result_id == '0 && o_result_priority == '0 && !o_entry_live, "empty result carries data")

endmodule

bind priority_collection_with_promote_unit pcwp_checker #(
    .DATA_WIDTH     (DATA_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_pcwp_checker (.*);
